// ===== rtl/core/adaptive_dct_quantizer_macros.svh =====
// assertion macros shared by the quantizer rtl
// depends on a clock named clk and an active-low reset named rst_n in scope
`ifndef ADAPTIVE_DCT_QUANTIZER_MACROS_SVH
`define ADAPTIVE_DCT_QUANTIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ADQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("adq assertion failed");
`define ADQ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("adq reset assertion failed");
`else
`define ADQ_ASSERT(lbl, prop)
`define ADQ_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/adq_pkg.sv =====
// types, constants and the luminance table of the quantizer
// no dependencies
package adq_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_QUALITY  = 2'd0;
  localparam logic [1:0] REG_ADAPTIVE = 2'd1;

  localparam int QUALITY_RESET = 50;

  // step limits in q8.8
  localparam int STEP_MIN = 256;
  localparam int STEP_MAX = 65280;

  // rebuild divider width
  localparam int BNUM_W = 23;

  // main pipeline widths
  localparam int DIV_BITS = 17;
  localparam int N_W      = 42;
  localparam int D_W      = 32;
  localparam int SNUM_W   = 27;
  localparam int MAG_W    = 17;
  localparam int FAC_W    = 11;

  // dequantize rounding: (x + 8000) / 16000
  localparam int DEQ_BIAS = 8000;
  localparam int DEQ_DIV  = 16000;
  localparam int Q_SCALE  = 256000;

  typedef enum logic [1:0] {
    BLD_IDLE,
    BLD_LOAD,
    BLD_DIV,
    BLD_WRITE
  } bld_state_t;

  // step memory write request from the rebuild sequencer
  typedef struct packed {
    logic        en;
    logic [5:0]  addr;
    logic [15:0] data;
  } bld_wr_t;

  // one divider stage
  typedef struct packed {
    logic                neg;
    logic [N_W-1:0]      rem;
    logic [D_W-1:0]      den;
    logic [DIV_BITS-1:0] quo;
  } div_t;

  localparam logic [6:0] LUMA [64] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

endpackage

// ===== rtl/core/adq_step_builder.sv =====
// rebuilds the 64 quality-scaled q8.8 steps with a serial divider
// depends on adq_pkg
module adq_step_builder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [6:0]          quality,
  output logic                busy,
  output adq_pkg::bld_wr_t    wr
);

  adq_pkg::bld_state_t               state_r, state_nxt;
  logic [5:0]                        k_r, k_nxt;
  logic [4:0]                        cnt_r, cnt_nxt;
  logic [adq_pkg::BNUM_W-1:0]        num_r, num_nxt;
  logic [adq_pkg::BNUM_W-1:0]        quo_r, quo_nxt;
  logic [7:0]                        den_r, den_nxt;
  logic [7:0]                        rem_r, rem_nxt;
  logic [6:0]                        qc;
  logic [6:0]                        t;
  logic [12:0]                       tq;
  logic [8:0]                        rem_sh;

  // clamp quality into 1..100
  always_comb begin
    if (quality == 7'd0) begin
      qc = 7'd1;
    end else if (quality > 7'd100) begin
      qc = 7'd100;
    end else begin
      qc = quality;
    end
  end

  assign t      = adq_pkg::LUMA[k_r];
  assign tq     = 13'(t) * 13'(7'd100 - qc);
  assign rem_sh = {rem_r, num_r[adq_pkg::BNUM_W-1]};

  // sequencer: load operands, divide one bit a cycle, write the step
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    wr.en     = 1'b0;
    wr.addr   = k_r;
    wr.data   = 16'(adq_pkg::STEP_MIN);
    if (quo_r > adq_pkg::BNUM_W'(adq_pkg::STEP_MAX)) begin
      wr.data = 16'(adq_pkg::STEP_MAX);
    end else if (quo_r > adq_pkg::BNUM_W'(adq_pkg::STEP_MIN)) begin
      wr.data = quo_r[15:0];
    end
    unique case (state_r)
      adq_pkg::BLD_IDLE: begin
      end
      adq_pkg::BLD_LOAD: begin
        if (qc < 7'd50) begin
          num_nxt = adq_pkg::BNUM_W'(t * 15'd25600) + adq_pkg::BNUM_W'(qc);
          den_nxt = {qc, 1'b0};
        end else begin
          num_nxt = adq_pkg::BNUM_W'({tq, 10'd0}) + adq_pkg::BNUM_W'(100);
          den_nxt = 8'd200;
        end
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = adq_pkg::BLD_DIV;
      end
      adq_pkg::BLD_DIV: begin
        num_nxt = {num_r[adq_pkg::BNUM_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = 8'(rem_sh - {1'b0, den_r});
          quo_nxt = {quo_r[adq_pkg::BNUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[7:0];
          quo_nxt = {quo_r[adq_pkg::BNUM_W-2:0], 1'b0};
        end
        cnt_nxt = 5'(cnt_r + 5'd1);
        if (cnt_r == 5'(adq_pkg::BNUM_W - 1)) begin
          state_nxt = adq_pkg::BLD_WRITE;
        end
      end
      adq_pkg::BLD_WRITE: begin
        wr.en = 1'b1;
        k_nxt = 6'(k_r + 6'd1);
        if (k_r == 6'd63) begin
          state_nxt = adq_pkg::BLD_IDLE;
        end else begin
          state_nxt = adq_pkg::BLD_LOAD;
        end
      end
      default: begin
        state_nxt = adq_pkg::BLD_IDLE;
      end
    endcase
    if (start) begin
      state_nxt = adq_pkg::BLD_LOAD;
      k_nxt     = '0;
      wr.en     = 1'b0;
    end
  end

  assign busy = (state_r != adq_pkg::BLD_IDLE);

  // state register, a full rebuild runs out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adq_pkg::BLD_LOAD;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== rtl/core/adaptive_dct_quantizer.sv =====
// quantizer top: config registers, step memory and the coefficient pipeline
// depends on adq_pkg, adq_step_builder and adaptive_dct_quantizer_macros.svh
//
// usage: one coefficient request enters on in_* per cycle while in_tready is
// high; in_tuser selects quantize (0) or dequantize (1). in_tdata carries
// index, value and block variance. each request yields one result on out_*
// through 22 register stages: three for step lookup and multiplies, eighteen
// divider stages, one output register. sustained rate is one request per
// cycle when out_tready does not stall and no rebuild runs; every stage has a
// valid bit and moves when the stage after it is free, so bubbles close up and
// a stalled out_tready holds results without loss.
// cfg_* writes quality (index 0) or adaptive mode (index 1). a quality write
// starts a rebuild of the 64 steps by a serial divider, one step at a time;
// in_tready is low meanwhile. reset loads quality 50, clears all valid bits
// and runs the same rebuild before the first request is taken.
`include "adaptive_dct_quantizer_macros.svh"
module adaptive_dct_quantizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // coef_index[5:0], coef_value[21:6], pixel_var[37:22]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_value[15:0]
  output logic        out_tuser,  // saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int NB = adq_pkg::DIV_BITS;

  logic [6:0]               quality_r;
  logic                     adaptive_r;
  logic                     bld_start;
  logic                     bld_busy;
  adq_pkg::bld_wr_t         bld_wr;
  logic [15:0]              step_mem [64];

  logic [5:0]               in_idx;
  logic [15:0]              in_val;
  logic [15:0]              in_var;
  logic [9:0]               var_c;
  logic                     in_acc;

  logic                     s1_v_r, s1_act_r, s1_neg_r;
  logic [adq_pkg::MAG_W-1:0] s1_mag_r;
  logic [adq_pkg::FAC_W-1:0] s1_fac_r;
  logic [15:0]              s1_step_r;
  logic                     s2_v_r, s2_act_r, s2_neg_r;
  logic [adq_pkg::MAG_W-1:0] s2_mag_r;
  logic [adq_pkg::SNUM_W-1:0] s2_snum_r;
  logic                     s3_v_r, s3_act_r, s3_neg_r;
  logic [32:0]              s3_pq_r;
  logic [adq_pkg::N_W-1:0]  s3_pd_r;
  logic [adq_pkg::SNUM_W-1:0] s3_snum_r;
  logic                     dv_r  [NB+1];
  adq_pkg::div_t            div_r [NB+1];
  adq_pkg::div_t            div_nxt;
  logic                     out_valid_r, out_sat_r;
  logic [15:0]              out_data_r;

  logic                     rdy_o, rdy1, rdy2, rdy3;
  logic                     dready [NB+1];
  logic [NB-1:0]            fq;
  logic [NB-1:0]            lim;

  // one restoring step: try the divisor shifted to quotient bit sh
  function automatic adq_pkg::div_t div_step(adq_pkg::div_t d, int sh);
    logic [adq_pkg::N_W+NB-1:0] dsh;
    logic [adq_pkg::N_W+NB-1:0] rx;
    adq_pkg::div_t              r;
    r   = d;
    dsh = (adq_pkg::N_W+NB)'(d.den) << sh;
    rx  = (adq_pkg::N_W+NB)'(d.rem);
    if (rx >= dsh) begin
      r.rem     = adq_pkg::N_W'(rx - dsh);
      r.quo[sh] = 1'b1;
    end
    return r;
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;
  assign bld_start = cfg_valid && (cfg_index == adq_pkg::REG_QUALITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quality_r  <= 7'(adq_pkg::QUALITY_RESET);
      adaptive_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        adq_pkg::REG_QUALITY:  quality_r  <= cfg_data;
        adq_pkg::REG_ADAPTIVE: adaptive_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  adq_step_builder u_bld (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (bld_start),
    .quality (quality_r),
    .busy    (bld_busy),
    .wr      (bld_wr)
  );

  // stage readiness, back to front
  always_comb begin
    rdy_o      = !out_valid_r || out_tready;
    dready[NB] = !dv_r[NB] || rdy_o;
    for (int j = NB - 1; j >= 0; j--) begin
      dready[j] = !dv_r[j] || dready[j+1];
    end
    rdy3 = !s3_v_r || dready[0];
    rdy2 = !s2_v_r || rdy3;
    rdy1 = !s1_v_r || rdy2;
  end

  assign in_tready = rdy1 && !bld_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[5:0];
  assign in_val    = in_tdata[21:6];
  assign in_var    = in_tdata[37:22];

  // variance clamp to 100..1000
  always_comb begin
    if (in_var < 16'd100) begin
      var_c = 10'd100;
    end else if (in_var > 16'd1000) begin
      var_c = 10'd1000;
    end else begin
      var_c = in_var[9:0];
    end
  end

  // step memory: rebuild writes, pipeline reads
  always_ff @(posedge clk) begin
    if (bld_wr.en) begin
      step_mem[bld_wr.addr] <= bld_wr.data;
    end
    if (rdy1) begin
      s1_step_r <= step_mem[in_idx];
    end
  end

  // stage 1: magnitude and adaptive factor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_acc;
    end
    if (rdy1) begin
      s1_act_r <= in_tuser;
      s1_neg_r <= in_val[15];
      s1_mag_r <= in_val[15] ? adq_pkg::MAG_W'(17'h10000 - {1'b0, in_val})
                             : {1'b0, in_val};
      s1_fac_r <= (adaptive_r && (in_idx != 6'd0)) ? adq_pkg::FAC_W'(11'd2000 - {1'b0, var_c})
                                                   : 11'd1000;
    end
  end

  // stage 2: effective step numerator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
    if (rdy2) begin
      s2_act_r  <= s1_act_r;
      s2_neg_r  <= s1_neg_r;
      s2_mag_r  <= s1_mag_r;
      s2_snum_r <= adq_pkg::SNUM_W'(s1_step_r * s1_fac_r);
    end
  end

  // stage 3: products for both operations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
    if (rdy3) begin
      s3_act_r  <= s2_act_r;
      s3_neg_r  <= s2_neg_r;
      s3_pq_r   <= 33'(s2_mag_r * 18'(adq_pkg::Q_SCALE));
      s3_pd_r   <= adq_pkg::N_W'(s2_mag_r * s2_snum_r);
      s3_snum_r <= s2_snum_r;
    end
  end

  // divider operands: quantize rounds via 2n+d over 2d, dequantize via constant
  always_comb begin
    div_nxt     = '0;
    div_nxt.neg = s3_neg_r;
    if (!s3_act_r) begin
      div_nxt.rem = adq_pkg::N_W'({s3_pq_r, 1'b0}) + adq_pkg::N_W'({s3_snum_r, 4'd0});
      div_nxt.den = adq_pkg::D_W'({s3_snum_r, 5'd0});
    end else begin
      div_nxt.rem = adq_pkg::N_W'(s3_pd_r + adq_pkg::N_W'(adq_pkg::DEQ_BIAS));
      div_nxt.den = adq_pkg::D_W'(adq_pkg::DEQ_DIV);
    end
  end

  // divider pipeline, one quotient bit per stage, msb is the overflow bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NB; j++) begin
        dv_r[j] <= 1'b0;
      end
    end else begin
      if (dready[0]) begin
        dv_r[0] <= s3_v_r;
      end
      for (int j = 0; j < NB; j++) begin
        if (dready[j+1]) begin
          dv_r[j+1] <= dv_r[j];
        end
      end
    end
    if (dready[0]) begin
      div_r[0] <= div_nxt;
    end
    for (int j = 0; j < NB; j++) begin
      if (dready[j+1]) begin
        div_r[j+1] <= div_step(div_r[j], NB - 1 - j);
      end
    end
  end

  // saturate and restore sign
  assign fq  = div_r[NB].quo;
  assign lim = div_r[NB].neg ? NB'(32768) : NB'(32767);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_o) begin
      out_valid_r <= dv_r[NB];
    end
    if (rdy_o) begin
      if (fq > lim) begin
        out_sat_r  <= 1'b1;
        out_data_r <= div_r[NB].neg ? 16'h8000 : 16'h7FFF;
      end else begin
        out_sat_r  <= 1'b0;
        out_data_r <= div_r[NB].neg ? 16'(~fq[15:0] + 16'd1) : fq[15:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // checks
  `ADQ_ASSERT(a_no_accept_in_rebuild, bld_busy |-> !in_tready)
  `ADQ_ASSERT(a_mem_write_only_busy, bld_wr.en |-> bld_busy)
  `ADQ_ASSERT(a_sat_at_limit, (out_valid_r && out_sat_r) |-> (out_data_r == 16'h7FFF || out_data_r == 16'h8000))
  `ADQ_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid_r && !s1_v_r)

endmodule
